>>> src/sv39ptw_pkg.sv
// Shared types and constants for the Sv39 page table walker.
// Used by sv39_page_table_walk_top; depends on nothing.
package sv39ptw_pkg;

   localparam int TABLE_PAGES_DEF  = 16;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int PPN_W            = 44;
   localparam int VA_W             = 39;
   localparam int PA_W             = 56;
   localparam int PTE_W            = 64;
   localparam int OFFSET_W         = 12;

   // PTE bit positions
   localparam int PTE_VALID_BIT = 0;
   localparam int PTE_USER_BIT  = 4;
   localparam int PTE_PPN_LSB   = 10;
   localparam int PTE_PPN_MSB   = 53;

   // walk levels
   localparam logic [1:0] LEVEL_ROOT = 2'd2;
   localparam logic [1:0] LEVEL_MID  = 2'd1;
   localparam logic [1:0] LEVEL_LEAF = 2'd0;

   // request modes
   localparam logic MODE_WRITE     = 1'b0;
   localparam logic MODE_TRANSLATE = 1'b1;

   // CSR indexes
   localparam logic CSR_ROOT_PAGE = 1'b0;
   localparam logic CSR_BASE_PAGE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_LIMIT   = 3'd1,
      STATUS_UPPER   = 3'd2,
      STATUS_LEAF    = 3'd3,
      STATUS_USER    = 3'd4,
      STATUS_OUTSIDE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_ISSUE,
      S_EVAL
   } walk_state_type;

   typedef struct packed {
      logic                mode;
      logic [3:0]          table_slot;
      logic [IDX_W-1:0]    entry_index;
      logic [PTE_W-1:0]    entry_value;
      logic [VA_W-1:0]     virt_addr;
      logic                need_user;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0] phys_addr;
      status_type      status;
   } rsp_type;

endpackage

>>> src/sv39ptw_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; used for the page table store of the walker.
module sv39ptw_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/sv39_page_table_walk_top.sv
// Sv39 three-level page table walker over an on-chip table store.
// Depends on sv39ptw_pkg and sv39ptw_ram.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-----------------------------
//   request | start, busy, req_data              | beat when start && !busy
//   result  | rsp_valid, rsp_data                | one-cycle strobe, no stall
//   csr     | csr_valid, csr_ready, csr_index,   | beat when csr_valid &&
//           | csr_data                           | csr_ready (ready always high)
//
// A table write beat gives its result strobe in the next cycle. A translation
// takes two steps per table level read (address check and store read in ISSUE,
// then entry check in EVAL) and its result strobes in the cycle after the last
// step; an early fault ends it sooner. The single store port serialises these.
// After reset the store is zeroed one entry a cycle, all TABLE_PAGES * 512
// entries (8192 by default), with busy high; CSR writes are taken throughout.
// The result side cannot stall; each result is shown for one cycle only.
module sv39_page_table_walk_top #(
   parameter int TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sv39ptw_pkg::req_type          req_data,
   output logic                          rsp_valid,
   output sv39ptw_pkg::rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [sv39ptw_pkg::PPN_W-1:0] csr_data
);

   localparam int DEPTH  = TABLE_PAGES * sv39ptw_pkg::ENTRIES_PER_PAGE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int PPN_W  = sv39ptw_pkg::PPN_W;
   localparam int IDX_W  = sv39ptw_pkg::IDX_W;

   sv39ptw_pkg::walk_state_type state_ff, state_in;
   logic [ADDR_W-1:0]           clr_addr_ff, clr_addr_in;
   logic [1:0]                  level_ff, level_in;
   logic [PPN_W-1:0]            pn_ff, pn_in;
   logic [sv39ptw_pkg::VA_W-1:0] va_ff, va_in;
   logic                        user_ff, user_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sv39ptw_pkg::rsp_type        rsp_ff, rsp_in;
   logic [PPN_W-1:0]            root_ff;
   logic [PPN_W-1:0]            base_ff;

   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_addr;
   logic [sv39ptw_pkg::PTE_W-1:0] ram_wdata;
   logic [sv39ptw_pkg::PTE_W-1:0] ram_rdata;

   // page-to-slot unit of the walk, used at every level
   logic [PPN_W:0]              slot_diff;
   logic                        outside;
   logic [SLOT_W-1:0]           walk_slot;
   logic [IDX_W-1:0]            walk_idx;
   logic [ADDR_W-1:0]           rd_addr;

   // table write path
   logic [IDX_W-1:0]            wr_slot_ext;
   logic                        wr_slot_ok;
   logic [ADDR_W-1:0]           wr_addr;

   assign slot_diff = {1'b0, pn_ff} - {1'b0, base_ff};
   assign outside   = slot_diff[PPN_W] || (slot_diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
   assign walk_slot = slot_diff[SLOT_W-1:0];

   always_comb begin
      case (level_ff)
         sv39ptw_pkg::LEVEL_ROOT: walk_idx = va_ff[38:30];
         sv39ptw_pkg::LEVEL_MID:  walk_idx = va_ff[29:21];
         default:                 walk_idx = va_ff[20:12];
      endcase
   end

   assign rd_addr     = ADDR_W'({walk_slot, walk_idx});
   assign wr_slot_ext = {5'b0, req_data.table_slot};
   assign wr_slot_ok  = wr_slot_ext < IDX_W'(TABLE_PAGES);
   assign wr_addr     = ADDR_W'({wr_slot_ext[SLOT_W-1:0], req_data.entry_index});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sv39ptw_pkg::S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == sv39ptw_pkg::CSR_ROOT_PAGE) begin
               root_ff <= csr_data;
            end else begin
               base_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      pn_ff    <= pn_in;
      va_ff    <= va_in;
      user_ff  <= user_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      level_in     = level_ff;
      pn_in        = pn_ff;
      va_in        = va_ff;
      user_in      = user_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_addr     = rd_addr;
      ram_wdata    = '0;

      unique case (state_ff)
         sv39ptw_pkg::S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_addr_ff;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = sv39ptw_pkg::S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         sv39ptw_pkg::S_IDLE: begin
            if (start) begin
               if (req_data.mode == sv39ptw_pkg::MODE_WRITE) begin
                  // out-of-range slots drop the write but still answer
                  ram_we           = wr_slot_ok;
                  ram_addr         = wr_addr;
                  ram_wdata        = req_data.entry_value;
                  rsp_valid_in     = 1'b1;
                  rsp_in.phys_addr = '0;
                  rsp_in.status    = sv39ptw_pkg::STATUS_OK;
               end else if (req_data.virt_addr[38]) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.phys_addr = '0;
                  rsp_in.status    = sv39ptw_pkg::STATUS_LIMIT;
               end else begin
                  va_in    = req_data.virt_addr;
                  user_in  = req_data.need_user;
                  pn_in    = root_ff;
                  level_in = sv39ptw_pkg::LEVEL_ROOT;
                  state_in = sv39ptw_pkg::S_ISSUE;
               end
            end
         end

         sv39ptw_pkg::S_ISSUE: begin
            if (outside) begin
               rsp_valid_in     = 1'b1;
               rsp_in.phys_addr = '0;
               rsp_in.status    = sv39ptw_pkg::STATUS_OUTSIDE;
               state_in         = sv39ptw_pkg::S_IDLE;
            end else begin
               state_in = sv39ptw_pkg::S_EVAL;
            end
         end

         sv39ptw_pkg::S_EVAL: begin
            if (!ram_rdata[sv39ptw_pkg::PTE_VALID_BIT]) begin
               rsp_valid_in     = 1'b1;
               rsp_in.phys_addr = '0;
               rsp_in.status    = (level_ff == sv39ptw_pkg::LEVEL_LEAF) ?
                                  sv39ptw_pkg::STATUS_LEAF : sv39ptw_pkg::STATUS_UPPER;
               state_in         = sv39ptw_pkg::S_IDLE;
            end else if (level_ff == sv39ptw_pkg::LEVEL_LEAF) begin
               rsp_valid_in = 1'b1;
               state_in     = sv39ptw_pkg::S_IDLE;
               if (user_ff && !ram_rdata[sv39ptw_pkg::PTE_USER_BIT]) begin
                  rsp_in.phys_addr = '0;
                  rsp_in.status    = sv39ptw_pkg::STATUS_USER;
               end else begin
                  rsp_in.phys_addr = {ram_rdata[sv39ptw_pkg::PTE_PPN_MSB:
                                                sv39ptw_pkg::PTE_PPN_LSB],
                                      va_ff[sv39ptw_pkg::OFFSET_W-1:0]};
                  rsp_in.status    = sv39ptw_pkg::STATUS_OK;
               end
            end else begin
               // descend to the next table page
               pn_in    = ram_rdata[sv39ptw_pkg::PTE_PPN_MSB:sv39ptw_pkg::PTE_PPN_LSB];
               level_in = level_ff - 1'b1;
               state_in = sv39ptw_pkg::S_ISSUE;
            end
         end

         default: begin
            state_in = sv39ptw_pkg::S_IDLE;
         end
      endcase
   end

   sv39ptw_ram #(
      .WIDTH  (sv39ptw_pkg::PTE_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign busy      = (state_ff != sv39ptw_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
